FILE: hdl/lltd_pkg.sv
// shared types and constants for the least loaded task dispatcher
package lltd_pkg;

    localparam int CORES_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int CORE_W = 5;
    localparam int KIND_W = 3;
    localparam int PAY_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_OUT
    } t_state;

endpackage

FILE: hdl/lltd_cell.sv
// one core cell: queue pointers, busy flag and one stage of the least loaded scan
module lltd_cell #(
    parameter int QUEUE_DEPTH = lltd_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W = 5,
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_my_idx,
    input  logic             i_scan_en,
    input  logic [CNT_W-1:0] i_best_cnt,
    input  logic [IDX_W-1:0] i_best_idx,
    output logic [CNT_W-1:0] o_best_cnt,
    output logic [IDX_W-1:0] o_best_idx,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic             i_set_busy,
    input  logic             i_clr_busy,
    output logic [CNT_W-1:0] o_count,
    output logic [PTR_W-1:0] o_head,
    output logic [PTR_W-1:0] o_tail,
    output logic             o_busy
);

    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic             r_busy;
    logic [CNT_W-1:0] r_bc;
    logic [IDX_W-1:0] r_bi;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_push) begin
                r_tail <= wrap(r_tail);
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_pop) begin
                r_head <= wrap(r_head);
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_set_busy) begin
                r_busy <= 1'b1;
            end
            if (i_clr_busy) begin
                r_busy <= 1'b0;
            end
        end
    end

    // scan stage: strict less keeps the lower index on ties
    always_ff @(posedge i_clk) begin
        if (i_scan_en) begin
            if (r_cnt < i_best_cnt) begin
                r_bc <= r_cnt;
                r_bi <= i_my_idx;
            end else begin
                r_bc <= i_best_cnt;
                r_bi <= i_best_idx;
            end
        end
    end

    assign o_best_cnt = r_bc;
    assign o_best_idx = r_bi;
    assign o_count = r_cnt;
    assign o_head = r_head;
    assign o_tail = r_tail;
    assign o_busy = r_busy;

endmodule

FILE: hdl/least_loaded_task_dispatcher_core.sv
// top level of the least loaded task dispatcher with ring work stealing
// submit: minimum count ripples through the cell chain in the scan state, then decide, read and output
// take and finish: decide, queue memory read, output, in that order
// one item at a time, a new item is accepted only back in idle; a stalled result holds the output state
// synchronous active-low reset clears counts, pointers, busy flags and control
// queue memory is not cleared; only written entries are ever read
module least_loaded_task_dispatcher_core #(
    parameter int CORES = lltd_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = lltd_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = lltd_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lltd_pkg::ACTION_W-1:0] i_action,
    input  logic [lltd_pkg::CORE_W-1:0]   i_core,
    input  logic [lltd_pkg::KIND_W-1:0]   i_kind,
    input  logic [lltd_pkg::PAY_W-1:0]    i_payload,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lltd_pkg::STATUS_W-1:0] o_status,
    output logic [lltd_pkg::CORE_W-1:0]   o_target_core,
    output logic [lltd_pkg::KIND_W-1:0]   o_task_kind,
    output logic [lltd_pkg::PAY_W-1:0]    o_task_payload,
    output logic                          o_stolen
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int ADDR_W = $clog2(CORES * QUEUE_DEPTH);
    localparam int ENT_W = lltd_pkg::KIND_W + PAYLOAD_BITS;
    localparam int SCNT_W = $clog2(CORES + 1);

    logic [ENT_W-1:0] r_mem [CORES*QUEUE_DEPTH];
    logic [ENT_W-1:0] r_rd;

    lltd_pkg::t_state r_state, n_state;
    logic [lltd_pkg::ACTION_W-1:0] r_act;
    logic [lltd_pkg::CORE_W-1:0]   r_core;
    logic [lltd_pkg::KIND_W-1:0]   r_kind;
    logic [PAYLOAD_BITS-1:0]       r_pay;
    logic [SCNT_W-1:0]             r_scnt;
    logic [IDX_W-1:0]              r_sel;
    logic                          r_rdsel;
    logic [lltd_pkg::STATUS_W-1:0] r_st;
    logic [lltd_pkg::CORE_W-1:0]   r_tgt;
    logic                          r_stl;

    logic                          r_ov;
    logic [lltd_pkg::STATUS_W-1:0] r_os;
    logic [lltd_pkg::CORE_W-1:0]   r_ot;
    logic [lltd_pkg::KIND_W-1:0]   r_ok;
    logic [lltd_pkg::PAY_W-1:0]    r_op;
    logic                          r_osl;

    logic [CNT_W-1:0] w_bc [CORES+1];
    logic [IDX_W-1:0] w_bi [CORES+1];
    logic [CNT_W-1:0] w_cnt [CORES];
    logic [PTR_W-1:0] w_head [CORES];
    logic [PTR_W-1:0] w_tail [CORES];
    logic             w_busy [CORES];
    logic [CORES-1:0] w_push, w_pop, w_setb, w_clrb;

    logic                     n_push, n_pop, n_setb, n_clrb, n_rdsel;
    logic [IDX_W-1:0]         n_pidx, n_oidx;
    logic [lltd_pkg::STATUS_W-1:0] n_st;
    logic [lltd_pkg::CORE_W-1:0]   n_tgt;
    logic                     n_stl;
    logic [IDX_W-1:0]         w_cidx, w_nb;
    logic                     w_in_rng;
    logic                     w_out_load;

    assign w_bc[0] = '1;
    assign w_bi[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CORES; g++) begin : g_cell
            lltd_cell #(
                .QUEUE_DEPTH(QUEUE_DEPTH),
                .IDX_W(IDX_W)
            ) u_cell (
                .i_clk(i_clk),
                .i_rst_n(i_rst_n),
                .i_my_idx(IDX_W'(g)),
                .i_scan_en(r_state == lltd_pkg::S_SCAN),
                .i_best_cnt(w_bc[g]),
                .i_best_idx(w_bi[g]),
                .o_best_cnt(w_bc[g+1]),
                .o_best_idx(w_bi[g+1]),
                .i_push(w_push[g]),
                .i_pop(w_pop[g]),
                .i_set_busy(w_setb[g]),
                .i_clr_busy(w_clrb[g]),
                .o_count(w_cnt[g]),
                .o_head(w_head[g]),
                .o_tail(w_tail[g]),
                .o_busy(w_busy[g])
            );
            assign w_push[g] = n_push && (n_pidx == IDX_W'(g));
            assign w_pop[g] = n_pop && (n_pidx == IDX_W'(g));
            assign w_setb[g] = n_setb && (n_oidx == IDX_W'(g));
            assign w_clrb[g] = n_clrb && (n_oidx == IDX_W'(g));
        end
    endgenerate

    assign w_in_rng = {1'b0, r_core} < (lltd_pkg::CORE_W + 1)'(CORES);
    assign w_cidx = r_core[IDX_W-1:0];
    assign w_nb = (w_cidx == IDX_W'(CORES - 1)) ? '0 : w_cidx + 1'b1;
    assign w_out_load = (r_state == lltd_pkg::S_OUT) && (!r_ov || i_ready);

    always_comb begin
        n_state = r_state;
        n_push = 1'b0;
        n_pop = 1'b0;
        n_setb = 1'b0;
        n_clrb = 1'b0;
        n_rdsel = 1'b0;
        n_pidx = w_cidx;
        n_oidx = w_cidx;
        n_st = lltd_pkg::ST_NONE;
        n_tgt = '0;
        n_stl = 1'b0;
        unique case (r_state)
            lltd_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_action == lltd_pkg::ACT_SUBMIT) ?
                              lltd_pkg::S_SCAN : lltd_pkg::S_DECIDE;
                end
            end
            lltd_pkg::S_SCAN: begin
                if (r_scnt == SCNT_W'(CORES - 1)) begin
                    n_state = lltd_pkg::S_DECIDE;
                end
            end
            lltd_pkg::S_DECIDE: begin
                n_state = lltd_pkg::S_READ;
                priority case (r_act)
                    lltd_pkg::ACT_SUBMIT: begin
                        n_tgt = lltd_pkg::CORE_W'(w_bi[CORES]);
                        n_pidx = w_bi[CORES];
                        if (w_bc[CORES] >= CNT_W'(QUEUE_DEPTH)) begin
                            n_st = lltd_pkg::ST_FULL;
                        end else begin
                            n_st = lltd_pkg::ST_OK;
                            n_push = 1'b1;
                        end
                    end
                    lltd_pkg::ACT_TAKE: begin
                        n_tgt = r_core;
                        if (!w_in_rng || w_cnt[w_cidx] == '0) begin
                            n_st = lltd_pkg::ST_EMPTY;
                        end else begin
                            n_st = lltd_pkg::ST_OK;
                            n_pop = 1'b1;
                            n_setb = 1'b1;
                            n_rdsel = 1'b1;
                        end
                    end
                    lltd_pkg::ACT_FINISH: begin
                        n_tgt = r_core;
                        if (w_in_rng) begin
                            n_clrb = 1'b1;
                            n_pidx = w_nb;
                            n_tgt = lltd_pkg::CORE_W'(w_nb);
                            if (w_cnt[w_nb] != '0 && !w_busy[w_nb]) begin
                                n_st = lltd_pkg::ST_OK;
                                n_pop = 1'b1;
                                n_rdsel = 1'b1;
                                n_stl = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lltd_pkg::S_READ: n_state = lltd_pkg::S_OUT;
            lltd_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = lltd_pkg::S_IDLE;
                end
            end
            default: n_state = lltd_pkg::S_IDLE;
        endcase
    end

    assign o_ready = (r_state == lltd_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lltd_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_scnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lltd_pkg::S_SCAN) begin
                r_scnt <= r_scnt + 1'b1;
            end else begin
                r_scnt <= '0;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_act <= i_action;
            r_core <= i_core;
            r_kind <= i_kind;
            r_pay <= i_payload[PAYLOAD_BITS-1:0];
        end
        if (r_state == lltd_pkg::S_DECIDE) begin
            r_st <= n_st;
            r_tgt <= n_tgt;
            r_stl <= n_stl;
            r_rdsel <= n_rdsel;
            r_sel <= n_pidx;
        end
        if (n_push) begin
            r_mem[ADDR_W'(n_pidx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(w_tail[n_pidx])]
                <= {r_kind, r_pay};
        end
        if (n_pop) begin
            r_rd <= r_mem[ADDR_W'(n_pidx) * ADDR_W'(QUEUE_DEPTH)
                          + ADDR_W'(w_head[n_pidx])];
        end
        if (w_out_load) begin
            r_os <= r_st;
            r_ot <= r_tgt;
            r_osl <= r_stl;
            r_ok <= r_rdsel ? r_rd[ENT_W-1:PAYLOAD_BITS] : '0;
            r_op <= r_rdsel ? lltd_pkg::PAY_W'(r_rd[PAYLOAD_BITS-1:0]) : '0;
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_os;
    assign o_target_core = r_ot;
    assign o_task_kind = r_ok;
    assign o_task_payload = r_op;
    assign o_stolen = r_osl;

endmodule

FILE: hdl/lltd_checker.sv
// port-level checks for the least loaded task dispatcher
module lltd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic       o_stolen,
    input logic [31:0] o_task_payload
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item accepted while one is in flight");

    a_stolen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stolen |-> o_status == lltd_pkg::ST_OK)
        else $error("stolen item without ok status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != lltd_pkg::ST_OK |-> o_task_payload == '0 && !o_stolen)
        else $error("failed item carries task data");

endmodule

bind least_loaded_task_dispatcher_core lltd_checker u_lltd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_status(o_status),
    .o_stolen(o_stolen),
    .o_task_payload(o_task_payload)
);

FILE: test/tb_least_loaded_task_dispatcher_core.sv
// testbench for the least loaded task dispatcher: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_least_loaded_task_dispatcher_core;

    localparam int N_CORES = lltd_pkg::CORES_DEF;
    localparam int DEPTH = lltd_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [lltd_pkg::STATUS_W-1:0] status;
        logic [lltd_pkg::CORE_W-1:0]   target;
        logic [lltd_pkg::KIND_W-1:0]   kind;
        logic [lltd_pkg::PAY_W-1:0]    payload;
        logic                          stolen;
    } t_dispatch;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [lltd_pkg::ACTION_W-1:0] i_action = '0;
    logic [lltd_pkg::CORE_W-1:0] i_core = '0;
    logic [lltd_pkg::KIND_W-1:0] i_kind = '0;
    logic [lltd_pkg::PAY_W-1:0] i_payload = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [lltd_pkg::STATUS_W-1:0] o_status;
    logic [lltd_pkg::CORE_W-1:0] o_target_core;
    logic [lltd_pkg::KIND_W-1:0] o_task_kind;
    logic [lltd_pkg::PAY_W-1:0] o_task_payload;
    logic o_stolen;

    // predictor state
    logic [lltd_pkg::KIND_W-1:0] q_kind [N_CORES][DEPTH];
    logic [lltd_pkg::PAY_W-1:0] q_pay [N_CORES][DEPTH];
    int q_head [N_CORES];
    int q_tail [N_CORES];
    int q_fill [N_CORES];
    bit q_busy [N_CORES];

    t_dispatch pending_results [$];
    int mismatches = 0;
    int cycles = 0;
    int results_seen = 0;
    int steals_seen = 0;
    int fulls_seen = 0;
    bit calm = 1'b0;

    least_loaded_task_dispatcher_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_core(i_core), .i_kind(i_kind), .i_payload(i_payload),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_target_core(o_target_core), .o_task_kind(o_task_kind),
        .o_task_payload(o_task_payload), .o_stolen(o_stolen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_dispatch dispatch(logic [lltd_pkg::ACTION_W-1:0] act,
                                           logic [lltd_pkg::CORE_W-1:0] c,
                                           logic [lltd_pkg::KIND_W-1:0] k,
                                           logic [lltd_pkg::PAY_W-1:0] p);
        t_dispatch r;
        int best;
        int nb;
        r = '0;
        r.status = lltd_pkg::ST_NONE;
        if (act == lltd_pkg::ACT_SUBMIT) begin
            best = 0;
            for (int i = 1; i < N_CORES; i++)
                if (q_fill[i] < q_fill[best]) best = i;
            r.target = lltd_pkg::CORE_W'(best);
            if (q_fill[best] >= DEPTH) begin
                r.status = lltd_pkg::ST_FULL;
            end else begin
                q_kind[best][q_tail[best]] = k;
                q_pay[best][q_tail[best]] = p;
                q_tail[best] = (q_tail[best] + 1) % DEPTH;
                q_fill[best]++;
                r.status = lltd_pkg::ST_OK;
            end
        end else if (act == lltd_pkg::ACT_TAKE) begin
            r.target = c;
            if (c >= N_CORES || q_fill[c] == 0) begin
                r.status = lltd_pkg::ST_EMPTY;
            end else begin
                r.status = lltd_pkg::ST_OK;
                r.kind = q_kind[c][q_head[c]];
                r.payload = q_pay[c][q_head[c]];
                q_head[c] = (q_head[c] + 1) % DEPTH;
                q_fill[c]--;
                q_busy[c] = 1'b1;
            end
        end else if (act == lltd_pkg::ACT_FINISH) begin
            r.target = c;
            if (c < N_CORES) begin
                q_busy[c] = 1'b0;
                nb = (int'(c) + 1) % N_CORES;
                r.target = lltd_pkg::CORE_W'(nb);
                if (q_fill[nb] > 0 && !q_busy[nb]) begin
                    r.status = lltd_pkg::ST_OK;
                    r.stolen = 1'b1;
                    r.kind = q_kind[nb][q_head[nb]];
                    r.payload = q_pay[nb][q_head[nb]];
                    q_head[nb] = (q_head[nb] + 1) % DEPTH;
                    q_fill[nb]--;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // result side: random stalls, checks against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_status, 0);
            end else begin
                t_dispatch e;
                e = pending_results.pop_front();
                results_seen <= results_seen + 1;
                if (o_stolen) steals_seen <= steals_seen + 1;
                if (o_status == lltd_pkg::ST_FULL) fulls_seen <= fulls_seen + 1;
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_target_core !== e.target)
                    report_mismatch("target_core", o_target_core, e.target);
                if (o_task_kind !== e.kind) report_mismatch("task_kind", o_task_kind, e.kind);
                if (o_task_payload !== e.payload)
                    report_mismatch("task_payload", o_task_payload, e.payload);
                if (o_stolen !== e.stolen) report_mismatch("stolen", o_stolen, e.stolen);
            end
        end
        i_ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic send_item(int act, int c, int k, int unsigned p);
        logic [lltd_pkg::ACTION_W-1:0] a_v;
        logic [lltd_pkg::CORE_W-1:0] c_v;
        logic [lltd_pkg::KIND_W-1:0] k_v;
        a_v = lltd_pkg::ACTION_W'(act);
        c_v = lltd_pkg::CORE_W'(c);
        k_v = lltd_pkg::KIND_W'(k);
        while (!calm && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= a_v;
        i_core <= c_v;
        i_kind <= k_v;
        i_payload <= p;
        pending_results.push_back(dispatch(a_v, c_v, k_v, p));
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(lltd_pkg::ACT_TAKE, 0, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, N_CORES - 1, 0, 0);
        send_item(lltd_pkg::ACT_SUBMIT, 31, 7, 32'hFFFF_FFFF);
        send_item(lltd_pkg::ACT_SUBMIT, 0, 0, 32'h0);
        send_item(lltd_pkg::ACT_SUBMIT, 5, 5, 32'hA5A5_5A5A);
        send_item(lltd_pkg::ACT_TAKE, 0, 0, 0);
        send_item(lltd_pkg::ACT_TAKE, 0, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, 0, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, 0, 0, 0);
        send_item(lltd_pkg::ACT_TAKE, N_CORES, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, 31, 0, 0);
        send_item(3, 17, 3, 32'h1234_5678);
        send_item(lltd_pkg::ACT_FINISH, 1, 0, 0);
        drain();
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < N_CORES * DEPTH + 3; i++)
            send_item(lltd_pkg::ACT_SUBMIT, $urandom, $urandom, $urandom);
        send_item(lltd_pkg::ACT_TAKE, 3, 0, 0);
        send_item(lltd_pkg::ACT_TAKE, 3, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, 2, 0, 0);
        send_item(lltd_pkg::ACT_FINISH, 3, 0, 0);
        for (int c = 0; c < N_CORES; c++)
            for (int j = 0; j < DEPTH + 1; j++) send_item(lltd_pkg::ACT_TAKE, c, 0, 0);
        drain();
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 2 && i < count / 2 + 150);
            r = $urandom_range(99);
            if (r < 45) send_item(lltd_pkg::ACT_SUBMIT, $urandom, $urandom, $urandom);
            else if (r < 70) send_item(lltd_pkg::ACT_TAKE, $urandom_range(N_CORES - 1), 0, 0);
            else if (r < 93) send_item(lltd_pkg::ACT_FINISH, $urandom_range(N_CORES - 1), 0, 0);
            else send_item($urandom, $urandom, $urandom, $urandom);
            if (i == count / 4) drain();
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        for (int c = 0; c < N_CORES; c++) begin
            q_head[c] = 0; q_tail[c] = 0; q_fill[c] = 0; q_busy[c] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_to_full();
        test_random(1000);
        repeat (50) @(posedge i_clk);
        $display("covered %0d results, %0d steals, %0d full reports", results_seen,
                 steals_seen, fulls_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
